[hdl/caseless_multi_signature_match_macros.svh]
// ---------------------------------------------------------------------------
// caseless_multi_signature_match_macros
// assertion shorthands for the signature matcher checker
// ---------------------------------------------------------------------------
`ifndef CASELESS_MULTI_SIGNATURE_MATCH_MACROS_SVH
`define CASELESS_MULTI_SIGNATURE_MATCH_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define CSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, with an implication from a condition to a property
`define CSM_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  `CSM_ASSERT(label, clk, rst_n, (cond) |-> (prop), msg)

`endif

[hdl/csm_pkg.sv]
// ---------------------------------------------------------------------------
// csm_pkg
// types, signature tables and helpers for the caseless signature matcher
// ---------------------------------------------------------------------------
package csm_pkg;

  localparam int unsigned NUM_A     = 7;
  localparam int unsigned NUM_B     = 6;
  localparam int unsigned SIG_ROW_W = 22;

  localparam logic [7:0] SIG_KEY       = 8'h37;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
  localparam logic [7:0] SIG_PAD       = 8'h00;

  localparam int unsigned CFG_WIDTH = 7;

  typedef enum logic {
    CFG_GROUP_A_EN = 1'b0,
    CFG_GROUP_B_EN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic group_a_hit;
    logic group_b_hit;
    logic stream_done;
  } out_t;

  typedef struct packed {
    logic group_a;
    logic group_b;
  } hit_t;

  // signature bytes stored xor SIG_KEY, first character at index 0
  localparam logic [7:0] SIG_A_ENC [NUM_A][SIG_ROW_W] = '{
    '{0: 8'h51, 1: 8'h45, 2: 8'h5e, 3: 8'h53, 4: 8'h56, default: SIG_PAD},
    '{0: 8'h51, 1: 8'h45, 2: 8'h5e, 3: 8'h53, 4: 8'h56, 5: 8'h1a, 6: 8'h56,
      7: 8'h50, 8: 8'h52, 9: 8'h59, 10: 8'h43, default: SIG_PAD},
    '{0: 8'h51, 1: 8'h45, 2: 8'h5e, 3: 8'h53, 4: 8'h56, 5: 8'h1a, 6: 8'h50,
      7: 8'h56, 8: 8'h53, 9: 8'h50, 10: 8'h52, 11: 8'h43, default: SIG_PAD},
    '{0: 8'h5b, 1: 8'h5e, 2: 8'h55, 3: 8'h51, 4: 8'h45, 5: 8'h5e, 6: 8'h53,
      7: 8'h56, default: SIG_PAD},
    '{0: 8'h50, 1: 8'h42, 2: 8'h5a, 3: 8'h1a, 4: 8'h5d, 5: 8'h44, 6: 8'h1a,
      7: 8'h5b, 8: 8'h58, 9: 8'h58, 10: 8'h47, default: SIG_PAD},
    '{0: 8'h5b, 1: 8'h5e, 2: 8'h59, 3: 8'h5d, 4: 8'h52, 5: 8'h54, 6: 8'h43,
      7: 8'h58, 8: 8'h45, default: SIG_PAD},
    '{0: 8'h45, 1: 8'h52, 2: 8'h19, 3: 8'h51, 4: 8'h45, 5: 8'h5e, 6: 8'h53,
      7: 8'h56, 8: 8'h19, 9: 8'h44, 10: 8'h52, 11: 8'h45, 12: 8'h41,
      13: 8'h52, 14: 8'h45, default: SIG_PAD}
  };

  localparam logic [7:0] SIG_B_ENC [NUM_B][SIG_ROW_W] = '{
    '{0: 8'h53, 1: 8'h52, 2: 8'h19, 3: 8'h45, 4: 8'h58, 5: 8'h55, 6: 8'h41,
      7: 8'h19, 8: 8'h56, 9: 8'h59, 10: 8'h53, 11: 8'h45, 12: 8'h58,
      13: 8'h5e, 14: 8'h53, 15: 8'h19, 16: 8'h4f, 17: 8'h47, 18: 8'h58,
      19: 8'h44, 20: 8'h52, 21: 8'h53},
    '{0: 8'h6f, 1: 8'h47, 2: 8'h58, 3: 8'h44, 4: 8'h52, 5: 8'h53, 6: 8'h75,
      7: 8'h45, 8: 8'h5e, 9: 8'h53, 10: 8'h50, 11: 8'h52, default: SIG_PAD},
    '{0: 8'h45, 1: 8'h5e, 2: 8'h45, 3: 8'h42, default: SIG_PAD},
    '{0: 8'h5b, 1: 8'h44, 2: 8'h47, 3: 8'h53, default: SIG_PAD},
    '{0: 8'h5b, 1: 8'h44, 2: 8'h47, 3: 8'h58, 4: 8'h44, 5: 8'h52,
      default: SIG_PAD},
    '{0: 8'h4f, 1: 8'h47, 2: 8'h58, 3: 8'h44, 4: 8'h52, 5: 8'h53,
      default: SIG_PAD}
  };

  localparam int unsigned SIG_A_LEN [NUM_A] = '{5, 11, 12, 8, 11, 9, 15};
  localparam int unsigned SIG_B_LEN [NUM_B] = '{22, 12, 4, 4, 6, 6};

  // ascii letters to lower case, everything else untouched
  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [7:0] sig_char(logic [7:0] enc);
    return fold_case(enc ^ SIG_KEY);
  endfunction

endpackage

[hdl/csm_history.sv]
// ---------------------------------------------------------------------------
// csm_history
// shift line of recent folded bytes, presents the compare window
// ---------------------------------------------------------------------------
module csm_history import csm_pkg::*; #(
  parameter int unsigned MAX_SIG_LEN = 22
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  logic                              clear_i,
  input  logic [7:0]                        cur_i,
  output logic [MAX_SIG_LEN-1:0][7:0]       window_o
);

  localparam int unsigned HistDepth = MAX_SIG_LEN - 1;

  logic [HistDepth-1:0][7:0] hist_q, hist_d;
  logic [HistDepth-1:0][7:0] hist_eff;

  // stream start wipes the history before the current byte is looked at
  assign hist_eff = clear_i ? '0 : hist_q;
  assign window_o = {hist_eff, cur_i};
  assign hist_d   = {hist_eff[HistDepth-2:0], cur_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (shift_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

[hdl/csm_matcher.sv]
// ---------------------------------------------------------------------------
// csm_matcher
// parallel compare of every signature ending at the newest byte
// ---------------------------------------------------------------------------
module csm_matcher import csm_pkg::*; #(
  parameter int unsigned MAX_SIG_LEN = 22
) (
  input  logic [MAX_SIG_LEN-1:0][7:0] window_i,
  input  logic [NUM_A-1:0]            group_a_enable_i,
  input  logic [NUM_B-1:0]            group_b_enable_i,
  output hit_t                        hit_o
);

  logic [NUM_A-1:0] match_a;
  logic [NUM_B-1:0] match_b;

  // window entry 0 is the newest byte, so the last signature char sits there
  for (genvar s = 0; s < NUM_A; s++) begin : g_sig_a
    localparam int unsigned Len = SIG_A_LEN[s];
    if (Len >= 1 && Len <= MAX_SIG_LEN && Len <= SIG_ROW_W) begin : g_fit
      logic [Len-1:0] eq;
      for (genvar k = 0; k < Len; k++) begin : g_chr
        assign eq[k] = (window_i[Len-1-k] == sig_char(SIG_A_ENC[s][k]));
      end
      assign match_a[s] = &eq;
    end else begin : g_nofit
      assign match_a[s] = 1'b0;
    end
  end

  for (genvar s = 0; s < NUM_B; s++) begin : g_sig_b
    localparam int unsigned Len = SIG_B_LEN[s];
    if (Len >= 1 && Len <= MAX_SIG_LEN && Len <= SIG_ROW_W) begin : g_fit
      logic [Len-1:0] eq;
      for (genvar k = 0; k < Len; k++) begin : g_chr
        assign eq[k] = (window_i[Len-1-k] == sig_char(SIG_B_ENC[s][k]));
      end
      assign match_b[s] = &eq;
    end else begin : g_nofit
      assign match_b[s] = 1'b0;
    end
  end

  assign hit_o.group_a = |(match_a & group_a_enable_i);
  assign hit_o.group_b = |(match_b & group_b_enable_i);

endmodule

[hdl/caseless_multi_signature_match.sv]
// ---------------------------------------------------------------------------
// caseless_multi_signature_match
// byte stream scanner against two built-in groups of caseless signatures
// ---------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i
//   out     | output    | out_valid_o / out_stall_i | out_data_o
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle while the output is not stalled; a taken byte reaches the
// output through the input register, then the compare and result register
// the compare window is the history shift line plus the input register byte
// reset clears history and hit flags and sets all signature enables
// a stalled output holds its transaction; the input register keeps taking
// bytes as long as the output register can move
// ---------------------------------------------------------------------------
module caseless_multi_signature_match import csm_pkg::*; #(
  parameter int unsigned MAX_SIG_LEN = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  logic             in_vld_q;
  in_t              in_q;
  logic             out_vld_q;
  out_t             out_q;
  logic             seen_a_q, seen_a_d;
  logic             seen_b_q, seen_b_d;
  logic [NUM_A-1:0] en_a_q;
  logic [NUM_B-1:0] en_b_q;
  logic             adv;
  logic             proc;
  logic             take_in;
  logic [MAX_SIG_LEN-1:0][7:0] window;
  hit_t             hit;

  assign adv        = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_a_q <= '1;
      en_b_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_A_EN: en_a_q <= cfg_wdata_i[NUM_A-1:0];
        CFG_GROUP_B_EN: en_b_q <= cfg_wdata_i[NUM_B-1:0];
        default:        ;
      endcase
    end
  end

  // input register, byte folded on the way in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q.data_byte    <= fold_case(in_data_i.data_byte);
      in_q.stream_start <= in_data_i.stream_start;
      in_q.stream_end   <= in_data_i.stream_end;
    end
  end

  csm_history #(
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (proc),
    .clear_i  (in_q.stream_start),
    .cur_i    (in_q.data_byte),
    .window_o (window)
  );

  csm_matcher #(
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_matcher (
    .window_i         (window),
    .group_a_enable_i (en_a_q),
    .group_b_enable_i (en_b_q),
    .hit_o            (hit)
  );

  assign seen_a_d = (seen_a_q && !in_q.stream_start) || hit.group_a;
  assign seen_b_d = (seen_b_q && !in_q.stream_start) || hit.group_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_a_q  <= 1'b0;
      seen_b_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (proc) begin
        seen_a_q <= seen_a_d;
        seen_b_q <= seen_b_d;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q.group_a_hit <= seen_a_d;
      out_q.group_b_hit <= seen_b_d;
      out_q.stream_done <= in_q.stream_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[hdl/csm_checker.sv]
// ---------------------------------------------------------------------------
// csm_checker
// port-level checks on the signature matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "caseless_multi_signature_match_macros.svh"

module csm_checker import csm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  `CSM_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   ##1 out_valid_o, "stalled output transaction dropped")
  `CSM_ASSERT_IMPL(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                   ##1 $stable(out_data_o), "stalled output payload changed")
  // empty output register means the pipe can always move
  `CSM_ASSERT_IMPL(a_no_stall_empty, clk_i, rst_ni, !out_valid_o,
                   !in_stall_o, "input stalled with empty output")
  // a fresh result comes from an accepted byte that passed the input register and the result register
  `CSM_ASSERT_IMPL(a_out_origin, clk_i, rst_ni, $rose(out_valid_o),
                   $past(in_valid_i && !in_stall_o, 2), "result without accepted byte")

endmodule

bind caseless_multi_signature_match csm_checker u_csm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
